/* design/circle_triangle_overlap_test_macros.svh */
// Assertion macros for the circle/triangle overlap test.
// Expects signals clk and rst_n in the scope of use.
`ifndef CIRCLE_TRIANGLE_OVERLAP_TEST_MACROS_SVH
`define CIRCLE_TRIANGLE_OVERLAP_TEST_MACROS_SVH

// same-cycle implication
`define CTOT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define CTOT_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* design/ctot_pkg.sv */
// Shared types and widths for the circle/triangle overlap test.
// No dependencies.
package ctot_pkg;

  localparam int CoordBits = 16;
  localparam int DiffW     = CoordBits + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int SumW      = ProdW + 1;
  localparam int MagW      = ProdW;
  localparam int LoW       = MagW / 2;
  localparam int HiW       = MagW - LoW;
  localparam int WideW     = 2 * MagW;
  localparam int RsqW      = 2 * (CoordBits - 1);
  localparam int NumLanes  = 3;
  localparam int PipeDepth = 7;

  typedef enum logic [1:0] {
    TEST_NONE   = 2'd0,
    TEST_VERTEX = 2'd1,
    TEST_CENTRE = 2'd2,
    TEST_EDGE   = 2'd3
  } test_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] centre_x;
    logic signed [CoordBits-1:0] centre_z;
    logic        [CoordBits-2:0] radius;
    logic signed [CoordBits-1:0] first_vertex_x;
    logic signed [CoordBits-1:0] first_vertex_z;
    logic signed [CoordBits-1:0] second_vertex_x;
    logic signed [CoordBits-1:0] second_vertex_z;
    logic signed [CoordBits-1:0] third_vertex_x;
    logic signed [CoordBits-1:0] third_vertex_z;
  } in_word_t;

  typedef struct packed {
    logic  overlap;
    test_t deciding_test;
  } out_word_t;

  // centre and edge end, both relative to the edge start vertex
  typedef struct packed {
    logic signed [DiffW-1:0] c_x;
    logic signed [DiffW-1:0] c_z;
    logic signed [DiffW-1:0] e_x;
    logic signed [DiffW-1:0] e_z;
  } lane_in_t;

  typedef struct packed {
    logic vertex_in;
    logic cross_neg;
    logic edge_hit;
  } lane_flags_t;

endpackage

/* design/ctot_edge_lane.sv */
// One vertex/edge lane: vertex distance, edge side and edge reach tests.
// Depends on ctot_pkg. Five register stages, no stall.
module ctot_edge_lane (
  input  logic                           clk,
  input  ctot_pkg::lane_in_t             lane_in,
  input  logic [ctot_pkg::RsqW-1:0]      rsq,
  output ctot_pkg::lane_flags_t          flags
);
  import ctot_pkg::*;

  logic signed [ProdW-1:0] sq_x_r, sq_z_r, cr_a_r, cr_b_r, k_a_r, k_b_r, len_a_r, len_b_r;
  logic signed [ProdW-1:0] sq_x_nxt, sq_z_nxt, cr_a_nxt, cr_b_nxt;
  logic signed [ProdW-1:0] k_a_nxt, k_b_nxt, len_a_nxt, len_b_nxt;
  logic signed [SumW-1:0]  csq_r, cross_r, k_r, len_r;
  logic signed [SumW-1:0]  csq_nxt, cross_nxt, k_nxt, len_nxt;
  logic signed [SumW-1:0]  rsq_ext;
  logic [MagW-1:0]         csq_m, len_m, k_m;
  logic [MagW+LoW-1:0]     a_lo_r, b_lo_r, a_lo_nxt, b_lo_nxt;
  logic [MagW+HiW-1:0]     a_hi_r, b_hi_r, a_hi_nxt, b_hi_nxt;
  logic [WideW-1:0]        lhs_r, rhs_r, lhs_nxt, rhs_nxt;
  lane_flags_t             s4_r, s5_r, flags_r, s4_nxt, flags_nxt;

  // products
  assign sq_x_nxt  = lane_in.c_x * lane_in.c_x;
  assign sq_z_nxt  = lane_in.c_z * lane_in.c_z;
  assign cr_a_nxt  = lane_in.e_z * lane_in.c_x;
  assign cr_b_nxt  = lane_in.e_x * lane_in.c_z;
  assign k_a_nxt   = lane_in.c_x * lane_in.e_x;
  assign k_b_nxt   = lane_in.c_z * lane_in.e_z;
  assign len_a_nxt = lane_in.e_x * lane_in.e_x;
  assign len_b_nxt = lane_in.e_z * lane_in.e_z;

  // sums
  assign rsq_ext   = SumW'($signed({1'b0, rsq}));
  assign csq_nxt   = SumW'(sq_x_r) + SumW'(sq_z_r) - rsq_ext;
  assign cross_nxt = SumW'(cr_a_r) - SumW'(cr_b_r);
  assign k_nxt     = SumW'(k_a_r) + SumW'(k_b_r);
  assign len_nxt   = SumW'(len_a_r) + SumW'(len_b_r);

  // sign tests and split products
  assign csq_m = csq_r[MagW-1:0];
  assign len_m = len_r[MagW-1:0];
  assign k_m   = k_r[MagW-1:0];
  assign s4_nxt.vertex_in = (csq_r <= 0);
  assign s4_nxt.cross_neg = (cross_r < 0);
  assign s4_nxt.edge_hit  = (k_r > 0) && (k_r < len_r) && (csq_r >= 0);
  assign a_lo_nxt = csq_m * len_m[LoW-1:0];
  assign a_hi_nxt = csq_m * len_m[MagW-1:LoW];
  assign b_lo_nxt = k_m * k_m[LoW-1:0];
  assign b_hi_nxt = k_m * k_m[MagW-1:LoW];

  // recombine, then compare
  assign lhs_nxt = (WideW'(a_hi_r) << LoW) + WideW'(a_lo_r);
  assign rhs_nxt = (WideW'(b_hi_r) << LoW) + WideW'(b_lo_r);
  assign flags_nxt.vertex_in = s5_r.vertex_in;
  assign flags_nxt.cross_neg = s5_r.cross_neg;
  assign flags_nxt.edge_hit  = s5_r.edge_hit && (lhs_r <= rhs_r);

  always_ff @(posedge clk) begin
    sq_x_r  <= sq_x_nxt;
    sq_z_r  <= sq_z_nxt;
    cr_a_r  <= cr_a_nxt;
    cr_b_r  <= cr_b_nxt;
    k_a_r   <= k_a_nxt;
    k_b_r   <= k_b_nxt;
    len_a_r <= len_a_nxt;
    len_b_r <= len_b_nxt;
    csq_r   <= csq_nxt;
    cross_r <= cross_nxt;
    k_r     <= k_nxt;
    len_r   <= len_nxt;
    s4_r    <= s4_nxt;
    a_lo_r  <= a_lo_nxt;
    a_hi_r  <= a_hi_nxt;
    b_lo_r  <= b_lo_nxt;
    b_hi_r  <= b_hi_nxt;
    s5_r    <= s4_r;
    lhs_r   <= lhs_nxt;
    rhs_r   <= rhs_nxt;
    flags_r <= flags_nxt;
  end

  assign flags = flags_r;

endmodule

/* design/circle_triangle_overlap_test.sv */
// Circle/triangle overlap test in the XZ plane, top level.
// Depends on ctot_pkg, ctot_edge_lane and the assertion macro header.
//
// Usage:
// - Input: drive one circle/triangle word on in_word and raise start; the
//   word is taken at every rising edge with start high and busy low. busy
//   is always low, so a new word may be taken every cycle.
// - Result: out_strobe is high for one cycle with out_word holding overlap
//   and the deciding test (vertex inside, centre inside, edge crossed,
//   checked in that order, else none).
// - Pipeline: input registers, lane stages, output register; throughput one
//   word per cycle. The depth is set by the multiply/add chain of the edge
//   reach test, split over three lanes of five register stages each, plus
//   the input and output registers.
// - Reset: synchronous, active low; clears the valid pipe, so words in
//   flight are dropped and no strobe follows.
// - The receiver cannot stall; results leave in order of arrival.
`include "circle_triangle_overlap_test_macros.svh"

module circle_triangle_overlap_test (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ctot_pkg::in_word_t  in_word,
  output logic                busy,
  output logic                out_strobe,
  output ctot_pkg::out_word_t out_word
);
  import ctot_pkg::*;

  logic [PipeDepth-1:0]    valid_r, valid_nxt;
  lane_in_t                lane_in_r [NumLanes];
  lane_in_t                lane_in_nxt [NumLanes];
  logic [CoordBits-2:0]    radius_r;
  logic [RsqW-1:0]         rsq_r, rsq_nxt;
  lane_flags_t             flags [NumLanes];
  out_word_t               out_word_r, out_word_nxt;
  logic                    vertex_any, centre_in, edge_any;

  assign busy      = 1'b0;
  assign valid_nxt = {valid_r[PipeDepth-2:0], start & ~busy};

  // lane 0: A to B, lane 1: B to C, lane 2: C to A
  always_comb begin
    lane_in_nxt[0].c_x = DiffW'(in_word.centre_x) - DiffW'(in_word.first_vertex_x);
    lane_in_nxt[0].c_z = DiffW'(in_word.centre_z) - DiffW'(in_word.first_vertex_z);
    lane_in_nxt[0].e_x = DiffW'(in_word.second_vertex_x) - DiffW'(in_word.first_vertex_x);
    lane_in_nxt[0].e_z = DiffW'(in_word.second_vertex_z) - DiffW'(in_word.first_vertex_z);
    lane_in_nxt[1].c_x = DiffW'(in_word.centre_x) - DiffW'(in_word.second_vertex_x);
    lane_in_nxt[1].c_z = DiffW'(in_word.centre_z) - DiffW'(in_word.second_vertex_z);
    lane_in_nxt[1].e_x = DiffW'(in_word.third_vertex_x) - DiffW'(in_word.second_vertex_x);
    lane_in_nxt[1].e_z = DiffW'(in_word.third_vertex_z) - DiffW'(in_word.second_vertex_z);
    lane_in_nxt[2].c_x = DiffW'(in_word.centre_x) - DiffW'(in_word.third_vertex_x);
    lane_in_nxt[2].c_z = DiffW'(in_word.centre_z) - DiffW'(in_word.third_vertex_z);
    lane_in_nxt[2].e_x = DiffW'(in_word.first_vertex_x) - DiffW'(in_word.third_vertex_x);
    lane_in_nxt[2].e_z = DiffW'(in_word.first_vertex_z) - DiffW'(in_word.third_vertex_z);
  end

  assign rsq_nxt = radius_r * radius_r;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    ctot_edge_lane u_lane (
      .clk     (clk),
      .lane_in (lane_in_r[i]),
      .rsq     (rsq_r),
      .flags   (flags[i])
    );
  end

  assign vertex_any = flags[0].vertex_in | flags[1].vertex_in | flags[2].vertex_in;
  assign centre_in  = flags[0].cross_neg & flags[1].cross_neg & flags[2].cross_neg;
  assign edge_any   = flags[0].edge_hit | flags[1].edge_hit | flags[2].edge_hit;

  always_comb begin
    if (vertex_any) begin
      out_word_nxt.deciding_test = TEST_VERTEX;
    end else if (centre_in) begin
      out_word_nxt.deciding_test = TEST_CENTRE;
    end else if (edge_any) begin
      out_word_nxt.deciding_test = TEST_EDGE;
    end else begin
      out_word_nxt.deciding_test = TEST_NONE;
    end
    out_word_nxt.overlap = (out_word_nxt.deciding_test != TEST_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_in_r  <= lane_in_nxt;
    radius_r   <= in_word.radius;
    rsq_r      <= rsq_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = valid_r[PipeDepth-1];
  assign out_word   = out_word_r;

  `CTOT_ASSERT_IMP(a_strobe_has_word, out_strobe, $past(start && !busy, PipeDepth), "strobe without an accepted word")
  `CTOT_ASSERT_DELAY(a_word_gives_strobe, start && !busy, PipeDepth, out_strobe, "accepted word gave no strobe")
  `CTOT_ASSERT_IMP(a_overlap_code, out_strobe, out_word.overlap == (out_word.deciding_test != TEST_NONE), "overlap disagrees with deciding test")

endmodule
